>>> src/kwm_pkg.sv
package kwm_pkg;

    // Width of one stored value.
    localparam int DATA_W = 32;

    // Request codes carried on the func port.
    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_RUN  = 1'b1
    } func_t;

endpackage

>>> src/kwm_ram.sv
module kwm_ram #(
    parameter int WIDTH = kwm_pkg::DATA_W,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/k_way_sorted_merge_top.sv
// Load request: busy stays low, so loads may follow every cycle.
// Run request over empty lists: the single result appears in the cycle after acceptance.
// Run request otherwise: busy stays high until the final result is shown; each
// result scans all list heads through the one memory read port.
// The receiver cannot stall; each result strobe lasts one cycle.
// Reset clears list counters and the overflow flag; the value memory is not cleared.
module k_way_sorted_merge_top #(
    parameter int LISTS    = 4,
    parameter int LIST_CAP = 16,
    localparam int LW     = $clog2(LISTS),
    localparam int DEPTH  = LISTS * LIST_CAP,
    localparam int AW     = $clog2(DEPTH),
    localparam int CW     = $clog2(LIST_CAP + 1),
    localparam int RW     = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               func,
    input  logic [LW-1:0]                      list_index,
    input  logic signed [kwm_pkg::DATA_W-1:0]  value,
    output logic                               strobe,
    output logic signed [kwm_pkg::DATA_W-1:0]  value_res,
    output logic                               last,
    output logic                               empty_res,
    output logic                               overflow
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_MERGE
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               fill_reg [LISTS];
    logic [CW-1:0]               fill_next [LISTS];
    logic [CW-1:0]               head_reg [LISTS];
    logic [CW-1:0]               head_next [LISTS];
    logic [RW-1:0]               total_reg, total_next;
    logic [RW-1:0]               remaining_reg, remaining_next;
    logic                        ovf_flag_reg, ovf_flag_next;
    logic                        ovf_run_reg, ovf_run_next;
    logic [LW-1:0]               scan_reg, scan_next;
    logic                        issue_reg, issue_next;
    logic                        pend_reg, pend_next;
    logic [LW-1:0]               cmp_idx_reg, cmp_idx_next;
    logic                        cmp_live_reg, cmp_live_next;
    logic                        found_reg, found_next;
    logic [LW-1:0]               best_idx_reg, best_idx_next;
    logic [kwm_pkg::DATA_W-1:0]  best_val_reg, best_val_next;
    logic                        strobe_reg, strobe_next;
    logic [kwm_pkg::DATA_W-1:0]  res_val_reg, res_val_next;
    logic                        last_reg, last_next;
    logic                        empty_reg, empty_next;
    logic                        ovf_out_reg, ovf_out_next;

    logic                        accept;
    logic                        in_range;
    logic                        list_full;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic [kwm_pkg::DATA_W-1:0]  rd_data;
    logic                        take;
    logic [kwm_pkg::DATA_W-1:0]  cand_val;
    logic [LW-1:0]               cand_idx;
    logic                        scan_done;

    assign accept   = start && !busy;
    assign in_range = ({1'b0, list_index} < (LW + 1)'(LISTS));
    assign list_full = in_range && (fill_reg[list_index] == CW'(LIST_CAP));

    // Loads write straight into the value memory at the tail of the chosen list.
    assign wr_en   = accept && (func == kwm_pkg::FUNC_LOAD) && in_range && !list_full;
    assign wr_addr = AW'(list_index) * AW'(LIST_CAP) + AW'(fill_reg[list_index]);

    // The scan reads the current head of one list per cycle.
    assign rd_addr = AW'(scan_reg) * AW'(LIST_CAP) + AW'(head_reg[scan_reg]);

    kwm_ram #(
        .WIDTH (kwm_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Compare stage: a strictly smaller head replaces the best, so ties keep the lower list.
    assign take = pend_reg && cmp_live_reg &&
                  (!found_reg || ($signed(rd_data) < $signed(best_val_reg)));
    assign cand_val  = take ? rd_data : best_val_reg;
    assign cand_idx  = take ? cmp_idx_reg : best_idx_reg;
    assign scan_done = pend_reg && (cmp_idx_reg == LW'(LISTS - 1));

    // Next-state logic for the controller and list counters.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        total_next     = total_reg;
        remaining_next = remaining_reg;
        ovf_flag_next  = ovf_flag_reg;
        ovf_run_next   = ovf_run_reg;
        scan_next      = scan_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        cmp_idx_next   = scan_reg;
        cmp_live_next  = head_reg[scan_reg] < fill_reg[scan_reg];
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        strobe_next    = 1'b0;
        res_val_next   = res_val_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        ovf_out_next   = ovf_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == kwm_pkg::FUNC_LOAD))
                begin
                    if (wr_en)
                    begin
                        fill_next[list_index] = fill_reg[list_index] + CW'(1);
                        total_next = total_reg + RW'(1);
                    end
                    else if (list_full)
                    begin
                        ovf_flag_next = 1'b1;
                    end
                end
                else if (accept)
                begin
                    ovf_flag_next = 1'b0;
                    if (total_reg == RW'(0))
                    begin
                        // All lists empty: one flagged result, nothing to clear.
                        strobe_next  = 1'b1;
                        res_val_next = '0;
                        last_next    = 1'b1;
                        empty_next   = 1'b1;
                        ovf_out_next = ovf_flag_reg;
                    end
                    else
                    begin
                        state_next     = ST_MERGE;
                        remaining_next = total_reg;
                        ovf_run_next   = ovf_flag_reg;
                        scan_next      = '0;
                        issue_next     = 1'b1;
                        found_next     = 1'b0;
                        for (int i = 0; i < LISTS; i++)
                        begin
                            head_next[i] = '0;
                        end
                    end
                end
            end

            ST_MERGE:
            begin
                // Issue side: one head read per cycle.
                if (issue_reg)
                begin
                    pend_next = 1'b1;
                    if (scan_reg == LW'(LISTS - 1))
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_next = scan_reg + LW'(1);
                    end
                end

                // Compare side: fold the arriving head into the running minimum.
                if (scan_done)
                begin
                    strobe_next  = 1'b1;
                    res_val_next = cand_val;
                    empty_next   = 1'b0;
                    ovf_out_next = ovf_run_reg;
                    last_next    = (remaining_reg == RW'(1));
                    head_next[cand_idx] = head_reg[cand_idx] + CW'(1);
                    remaining_next = remaining_reg - RW'(1);
                    found_next   = 1'b0;
                    if (remaining_reg == RW'(1))
                    begin
                        state_next = ST_IDLE;
                        issue_next = 1'b0;
                        total_next = '0;
                        for (int i = 0; i < LISTS; i++)
                        begin
                            fill_next[i] = '0;
                            head_next[i] = '0;
                        end
                    end
                    else
                    begin
                        scan_next  = '0;
                        issue_next = 1'b1;
                    end
                end
                else if (pend_reg)
                begin
                    found_next    = found_reg || take;
                    best_val_next = cand_val;
                    best_idx_next = cand_idx;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            remaining_reg <= '0;
            ovf_flag_reg  <= 1'b0;
            ovf_run_reg   <= 1'b0;
            scan_reg      <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            strobe_reg    <= 1'b0;
            cmp_idx_reg   <= '0;
            cmp_live_reg  <= 1'b0;
            best_idx_reg  <= '0;
            best_val_reg  <= '0;
            res_val_reg   <= '0;
            last_reg      <= 1'b0;
            empty_reg     <= 1'b0;
            ovf_out_reg   <= 1'b0;
            for (int i = 0; i < LISTS; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            remaining_reg <= remaining_next;
            ovf_flag_reg  <= ovf_flag_next;
            ovf_run_reg   <= ovf_run_next;
            scan_reg      <= scan_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            strobe_reg    <= strobe_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_live_reg  <= cmp_live_next;
            best_idx_reg  <= best_idx_next;
            best_val_reg  <= best_val_next;
            res_val_reg   <= res_val_next;
            last_reg      <= last_next;
            empty_reg     <= empty_next;
            ovf_out_reg   <= ovf_out_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign value_res = $signed(res_val_reg);
    assign last      = last_reg;
    assign empty_res = empty_reg;
    assign overflow  = ovf_out_reg;

`ifndef SYNTHESIS
    // An empty-list result is always the only, hence last, result of its run.
    assert property (@(posedge clk) disable iff (!rst_n) strobe && empty_res |-> last)
        else $error("empty result not marked last");

    // The block is free again once the final result of a run is shown.
    assert property (@(posedge clk) disable iff (!rst_n) strobe && last |-> !busy)
        else $error("busy after final result");

    // A merge in progress always has results left to give.
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> remaining_reg != RW'(0))
        else $error("merge running with no results left");

    // The memory is never written while a merge is reading it.
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !wr_en)
        else $error("memory write during merge");

    // Every finished scan of a merge delivers a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) busy && scan_done |=> strobe)
        else $error("scan finished without result");
`endif

endmodule
